FILE: rtl/core/pdec_pkg.sv
// Shared types and constants for the press duration event classifier.
package pdec_pkg;

    localparam int unsigned TimeW     = 32;
    localparam int unsigned CfgW      = 16;
    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned FifoDepth = 4;
    localparam int unsigned FifoAw    = 2;
    localparam int unsigned FifoCntW  = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SHORT_MIN   = 3'd0,
        REG_SHORT_MAX   = 3'd1,
        REG_LONG_MIN    = 3'd2,
        REG_LONG_MAX    = 3'd3,
        REG_HOLD_REWIND = 3'd4,
        REG_HEARTBEAT   = 3'd5
    } t_reg_idx;

    localparam logic [CfgW-1:0] RstShortMin   = 16'd20;
    localparam logic [CfgW-1:0] RstShortMax   = 16'd250;
    localparam logic [CfgW-1:0] RstLongMin    = 16'd500;
    localparam logic [CfgW-1:0] RstLongMax    = 16'd5000;
    localparam logic [CfgW-1:0] RstHoldRewind = 16'd4800;
    localparam logic [CfgW-1:0] RstHeartbeat  = 16'd50;

    typedef struct packed {
        logic [TimeW-1:0] time_ms;
        logic             button_a_level;
        logic             button_b_level;
        logic             status_a;
        logic             status_b;
    } t_in;

    typedef struct packed {
        logic a_on;
        logic a_off;
        logic b_on;
        logic b_off;
        logic frame_status_a;
        logic frame_status_b;
        logic last;
    } t_out;

    typedef struct packed {
        logic [CfgW-1:0] short_min_ms;
        logic [CfgW-1:0] short_max_ms;
        logic [CfgW-1:0] long_min_ms;
        logic [CfgW-1:0] long_max_ms;
        logic [CfgW-1:0] hold_rewind_ms;
        logic [CfgW-1:0] heartbeat_ms;
    } t_cfg;

    typedef struct packed {
        logic on;
        logic off;
    } t_btn_evt;

endpackage

FILE: rtl/core/press_duration_event_classifier_top.sv
// Top level of the press duration event classifier.
// Each input transaction is one sample (timestamp, two active-low button
// levels, two status bits). The sample is registered, then classified from
// the input register: a release whose held time lies strictly inside the
// short window gives an "on" event, strictly inside the long window an
// "off" event; a button held past long_max_ms repeats "off" and sets its
// press time to hold_rewind_ms before the sample time. Each event makes one
// output frame (button A first); with no event and more than heartbeat_ms
// since the last frame, a frame with no event bits goes out. The final
// frame of a sample carries last = 1. Rate: one sample per clock while the
// queue has room; the first frame of a sample passes the input register
// and then the frame queue before it is valid at the output. Frames drain
// through a 4-entry queue with one output port, so a sample that makes two
// frames leaves one frame at a time, and sustained throughput is one frame
// per cycle while the output is ready. A registered sample waits, and the
// input stalls, while more than two frames are queued. Configuration is a
// plain write port, to be used only while no sample is in flight.
module press_duration_event_classifier_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [pdec_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [pdec_pkg::CfgW-1:0]    i_cfg_wdata,
    // sample input
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  pdec_pkg::t_in                i_in_data,
    // frame output
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output pdec_pkg::t_out               o_out_data
);
    import pdec_pkg::*;

    // ---------------- configuration registers ----------------
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_min_ms   <= RstShortMin;
            r_cfg.short_max_ms   <= RstShortMax;
            r_cfg.long_min_ms    <= RstLongMin;
            r_cfg.long_max_ms    <= RstLongMax;
            r_cfg.hold_rewind_ms <= RstHoldRewind;
            r_cfg.heartbeat_ms   <= RstHeartbeat;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_SHORT_MIN:   r_cfg.short_min_ms   <= i_cfg_wdata;
                REG_SHORT_MAX:   r_cfg.short_max_ms   <= i_cfg_wdata;
                REG_LONG_MIN:    r_cfg.long_min_ms    <= i_cfg_wdata;
                REG_LONG_MAX:    r_cfg.long_max_ms    <= i_cfg_wdata;
                REG_HOLD_REWIND: r_cfg.hold_rewind_ms <= i_cfg_wdata;
                REG_HEARTBEAT:   r_cfg.heartbeat_ms   <= i_cfg_wdata;
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                r_in_valid;
    t_in                 r_in;
    logic [FifoCntW-1:0] r_count;
    logic                advance;

    // a sample moves on only when the queue can take two frames
    assign advance    = r_in_valid && (r_count <= FifoCntW'(FifoDepth - 2));
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // ---------------- per-button classification ----------------
    t_btn_evt evt_a;
    t_btn_evt evt_b;

    pdec_button u_btn_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_now   (r_in.time_ms),
        .i_level (r_in.button_a_level),
        .i_cfg   (r_cfg),
        .o_evt   (evt_a)
    );

    pdec_button u_btn_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_now   (r_in.time_ms),
        .i_level (r_in.button_b_level),
        .i_cfg   (r_cfg),
        .o_evt   (evt_b)
    );

    // ---------------- frame building ----------------
    logic [TimeW-1:0] r_last_frame;
    logic [TimeW-1:0] idle_time;
    logic             fa;
    logic             fb;
    logic             hb;
    t_out             frm_a;
    t_out             frm_b;
    t_out             frm_hb;
    t_out             frm0;
    logic [1:0]       n_push;

    assign fa        = evt_a.on || evt_a.off;
    assign fb        = evt_b.on || evt_b.off;
    assign idle_time = r_in.time_ms - r_last_frame;
    // an event frame restamps the frame time, so heartbeat only when quiet
    assign hb        = !fa && !fb && (idle_time > {16'd0, r_cfg.heartbeat_ms});

    always_comb begin
        frm_a                = '0;
        frm_a.a_on           = evt_a.on;
        frm_a.a_off          = evt_a.off;
        frm_a.frame_status_a = r_in.status_a;
        frm_a.frame_status_b = r_in.status_b;
        frm_a.last           = !fb;

        frm_b                = '0;
        frm_b.b_on           = evt_b.on;
        frm_b.b_off          = evt_b.off;
        frm_b.frame_status_a = r_in.status_a;
        frm_b.frame_status_b = r_in.status_b;
        frm_b.last           = 1'b1;

        frm_hb                = '0;
        frm_hb.frame_status_a = r_in.status_a;
        frm_hb.frame_status_b = r_in.status_b;
        frm_hb.last           = 1'b1;

        if (fa) begin
            frm0 = frm_a;
        end else if (fb) begin
            frm0 = frm_b;
        end else begin
            frm0 = frm_hb;
        end

        if (!advance) begin
            n_push = 2'd0;
        end else if (fa && fb) begin
            n_push = 2'd2;
        end else if (fa || fb || hb) begin
            n_push = 2'd1;
        end else begin
            n_push = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_frame <= '0;
        end else if (advance && (fa || fb || hb)) begin
            r_last_frame <= r_in.time_ms;
        end
    end

    // ---------------- frame queue ----------------
    t_out              r_fifo [FifoDepth];
    logic [FifoAw-1:0] r_wr_ptr;
    logic [FifoAw-1:0] r_rd_ptr;
    logic [FifoAw-1:0] wr_ptr_1;
    logic              pop;

    assign wr_ptr_1    = r_wr_ptr + FifoAw'(1);
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_fifo[r_wr_ptr] <= frm0;
        end
        if (n_push == 2'd2) begin
            r_fifo[wr_ptr_1] <= frm_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FifoAw'(n_push);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FifoAw'(1);
            end
            r_count <= r_count + FifoCntW'(n_push) - FifoCntW'(pop);
        end
    end

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FifoCntW'(FifoDepth))
        else $error("frame queue overfilled");

    a_frame_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_push != 2'd0) |=> o_out_valid)
        else $error("pushed frame not visible at output");

    a_stall_holds_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_last_frame_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_last_frame))
        else $error("frame time changed without a sample");

endmodule

FILE: rtl/core/pdec_button.sv
// Per-button press tracker: edge detect, duration windows and hold repeat.
module pdec_button (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic [pdec_pkg::TimeW-1:0] i_now,
    input  logic                     i_level,
    input  pdec_pkg::t_cfg           i_cfg,
    output pdec_pkg::t_btn_evt       o_evt
);
    import pdec_pkg::*;

    logic             r_prev;
    logic [TimeW-1:0] r_press;
    logic [TimeW-1:0] n_press;
    logic [TimeW-1:0] held;
    logic             released;
    logic             pressed;
    logic             in_short;
    logic             in_long;
    logic             hold;

    // held time, modulo 2^32
    assign held     = i_now - r_press;
    assign released = !r_prev && i_level;
    assign pressed  = r_prev && !i_level;

    assign in_short = (held > {16'd0, i_cfg.short_min_ms})
                   && (held < {16'd0, i_cfg.short_max_ms});
    assign in_long  = (held > {16'd0, i_cfg.long_min_ms})
                   && (held < {16'd0, i_cfg.long_max_ms});
    assign hold     = !r_prev && (held > {16'd0, i_cfg.long_max_ms});

    // hold wins over a release class; short tested before long
    assign o_evt.on  = released && in_short && !hold;
    assign o_evt.off = hold || (released && !in_short && in_long);

    always_comb begin
        if (hold) begin
            n_press = i_now - {16'd0, i_cfg.hold_rewind_ms};
        end else if (pressed) begin
            n_press = i_now;
        end else begin
            n_press = r_press;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b0;
            r_press <= '0;
        end else if (i_step) begin
            r_prev  <= i_level;
            r_press <= n_press;
        end
    end

endmodule
